### rtl/core/hls2rgb_pkg.sv
// hls2rgb_pkg: field widths, stream bus widths and the hue ramp region codes
// for the hls to rgb converter; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hls2rgb_pkg;

    // fixed widths of the stream fields
    localparam int HUE_W       = 16;
    localparam int CH_W        = 17;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // piece of the hue ramp that a channel hue falls in
    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } t_region;

endpackage

`default_nettype wire

### rtl/core/hls_to_rgb_converter_unit.sv
// hls_to_rgb_converter_unit: five stage pipelined hls to rgb colour converter
// depends on hls2rgb_pkg for field widths and ramp region codes
`timescale 1ns / 1ps
`default_nettype none

// Converts one hue, lightness, saturation triple into red, green and blue in
// unsigned fixed point with FRAC_BITS fraction bits (1 << FRAC_BITS is 1.0).
// Hue is a fraction of a full turn and wraps; lightness and saturation above
// 1.0 are clipped to 1.0. The block takes one transaction every clock cycle
// unless a full pipeline is stalled. There are five register stages: hue
// offsets and clipping, the m2 multiply with the ramp regions and slope
// factors, m1, m2 and their spread, the three ramp multiplies, and the
// output register, which holds a result valid on the master side.
// Every stage has its own valid bit and fills any bubble, so a stall on the
// master side only backs up the input once the whole pipeline is full. No
// transaction is taken while reset is held. Zero saturation needs no special
// path: m1 and m2 both come out equal to lightness, so every channel equals
// lightness.
module hls_to_rgb_converter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave side: hue [15:0], lightness [32:16], saturation [49:33], zeros above
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire [hls2rgb_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // master side: red [16:0], green [33:17], blue [50:34], zeros above
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [hls2rgb_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // value width: every internal level lies in 0 .. 1.0
    localparam int VW    = FRAC_BITS + 1;
    localparam int LW    = (VW > hls2rgb_pkg::CH_W) ? VW : hls2rgb_pkg::CH_W;
    localparam int HXW   = (FRAC_BITS > hls2rgb_pkg::HUE_W) ? FRAC_BITS : hls2rgb_pkg::HUE_W;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int THIRD_I = ONE_I / 3;
    localparam int PW    = 2 * VW + 1;

    localparam logic [VW-1:0]        ONE      = VW'(ONE_I);
    localparam logic [FRAC_BITS-1:0] THIRD    = FRAC_BITS'(THIRD_I);
    localparam logic [FRAC_BITS-1:0] TWO_THRD = FRAC_BITS'(ONE_I - THIRD_I);

    // ramp region of one channel hue
    function automatic hls2rgb_pkg::t_region f_region(input logic [FRAC_BITS-1:0] h);
        logic [FRAC_BITS+2:0] h6;
        h6 = {h, 2'b00} + {1'b0, h, 1'b0};
        if (h6 < (FRAC_BITS+3)'(ONE_I)) begin
            return hls2rgb_pkg::REG_RISE;
        end else if (!h[FRAC_BITS-1]) begin
            return hls2rgb_pkg::REG_HIGH;
        end else if (h6[FRAC_BITS+2:1] < (FRAC_BITS+2)'(2 * ONE_I)) begin
            return hls2rgb_pkg::REG_FALL;
        end else begin
            return hls2rgb_pkg::REG_LOW;
        end
    endfunction

    // multiplier for the rising and falling slopes, zero on the flat parts
    function automatic logic [VW-1:0] f_factor(input logic [FRAC_BITS-1:0] h);
        logic [FRAC_BITS+2:0] h6;
        logic [FRAC_BITS+2:0] fall;
        h6   = {h, 2'b00} + {1'b0, h, 1'b0};
        fall = (FRAC_BITS+3)'(4 * ONE_I) - h6;
        case (f_region(h))
            hls2rgb_pkg::REG_RISE: return VW'(h6);
            hls2rgb_pkg::REG_FALL: return VW'(fall);
            default:               return '0;
        endcase
    endfunction

    // per stage ready: a stage loads when it is empty or its successor moves
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign w_rdy5 = !r_v5 || i_m_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    // nothing is taken while reset is held
    assign o_s_tready = w_rdy1 && i_rst_n;
    assign o_m_tvalid = r_v5;

    // input unpacking and clipping
    logic [hls2rgb_pkg::HUE_W-1:0] w_hue;
    logic [LW-1:0]                 w_l_ext;
    logic [LW-1:0]                 w_s_ext;
    logic [HXW-1:0]                w_h_ext;
    logic [FRAC_BITS-1:0]          n_h1 [3];
    logic [VW-1:0]                 n_l1;
    logic [VW-1:0]                 n_s1;

    assign w_hue   = i_s_tdata[15:0];
    assign w_l_ext = LW'(i_s_tdata[32:16]);
    assign w_s_ext = LW'(i_s_tdata[49:33]);
    assign w_h_ext = HXW'(w_hue);

    always_comb begin
        n_h1[1] = w_h_ext[FRAC_BITS-1:0];
        n_h1[0] = n_h1[1] + THIRD;      // red leads by a third of a turn
        n_h1[2] = n_h1[1] + TWO_THRD;   // blue trails by a third
        n_l1 = (w_l_ext > LW'(ONE_I)) ? ONE : VW'(w_l_ext);
        n_s1 = (w_s_ext > LW'(ONE_I)) ? ONE : VW'(w_s_ext);
    end

    // stage 1: channel hues, clipped levels
    logic [FRAC_BITS-1:0] r_h1 [3];
    logic [VW-1:0]        r_l1;
    logic [VW-1:0]        r_s1;

    // stage 2: m2 product, ramp regions and slope factors
    logic [PW-1:0]          r_prod2;
    logic                   r_hi2;
    logic [VW-1:0]          r_l2;
    logic [VW-1:0]          r_s2;
    hls2rgb_pkg::t_region   r_reg2 [3];
    logic [VW-1:0]          r_fac2 [3];

    logic                   n_hi2;
    logic [VW:0]            n_mb2;

    assign n_hi2 = (r_l1 > VW'(ONE_I / 2));
    assign n_mb2 = n_hi2 ? {1'b0, r_s1} : ({1'b0, ONE} + {1'b0, r_s1});

    // stage 3: m1, m2 and their spread
    logic [VW-1:0]          r_m1_3;
    logic [VW-1:0]          r_m2_3;
    logic [VW-1:0]          r_diff3;
    hls2rgb_pkg::t_region   r_reg3 [3];
    logic [VW-1:0]          r_fac3 [3];

    logic [VW-1:0]          n_q3;
    logic [VW:0]            n_sum3;
    logic [VW-1:0]          n_m2_3;
    logic [VW:0]            n_m1w3;
    logic [VW-1:0]          n_m1_3;

    always_comb begin
        n_q3   = VW'(r_prod2 >> FRAC_BITS);
        n_sum3 = {1'b0, r_l2} + {1'b0, r_s2} - {1'b0, n_q3};
        n_m2_3 = r_hi2 ? VW'(n_sum3) : n_q3;
        n_m1w3 = {r_l2, 1'b0} - {1'b0, n_m2_3};
        n_m1_3 = VW'(n_m1w3);
    end

    // stage 4: slope products
    logic [VW-1:0]          r_m1_4;
    logic [VW-1:0]          r_m2_4;
    logic [2*VW-1:0]        r_p4   [3];
    hls2rgb_pkg::t_region   r_reg4 [3];

    // stage 5: output levels
    logic [hls2rgb_pkg::CH_W-1:0] r_rgb5 [3];
    logic [hls2rgb_pkg::CH_W-1:0] n_rgb5 [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_reg4[c])
                hls2rgb_pkg::REG_RISE,
                hls2rgb_pkg::REG_FALL: n_rgb5[c] = hls2rgb_pkg::CH_W'(
                    {1'b0, r_m1_4} + (VW+1)'(r_p4[c] >> FRAC_BITS));
                hls2rgb_pkg::REG_HIGH: n_rgb5[c] = hls2rgb_pkg::CH_W'(r_m2_4);
                default:               n_rgb5[c] = hls2rgb_pkg::CH_W'(r_m1_4);
            endcase
        end
    end

    assign o_m_tdata = {
        (hls2rgb_pkg::OUT_TDATA_W - 3 * hls2rgb_pkg::CH_W)'(0),
        r_rgb5[2], r_rgb5[1], r_rgb5[0]
    };

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_h1 <= n_h1;
            r_l1 <= n_l1;
            r_s1 <= n_s1;
        end
        if (w_rdy2) begin
            r_prod2 <= PW'(r_l1 * n_mb2);
            r_hi2   <= n_hi2;
            r_l2    <= r_l1;
            r_s2    <= r_s1;
            for (int c = 0; c < 3; c++) begin
                r_reg2[c] <= f_region(r_h1[c]);
                r_fac2[c] <= f_factor(r_h1[c]);
            end
        end
        if (w_rdy3) begin
            r_m1_3  <= n_m1_3;
            r_m2_3  <= n_m2_3;
            r_diff3 <= n_m2_3 - n_m1_3;
            r_reg3  <= r_reg2;
            r_fac3  <= r_fac2;
        end
        if (w_rdy4) begin
            r_m1_4 <= r_m1_3;
            r_m2_4 <= r_m2_3;
            r_reg4 <= r_reg3;
            for (int c = 0; c < 3; c++) begin
                r_p4[c] <= (2*VW)'(r_diff3 * r_fac3[c]);
            end
        end
        if (w_rdy5) begin
            r_rgb5 <= n_rgb5;
        end
    end

`ifndef SYNTH
    // the ramp spread is never negative
    a_m2_ge_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_m2_3 >= r_m1_3))
        else $error("m2 below m1");

    // slope factors stay within one full step
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_fac2[0] <= ONE) && (r_fac2[1] <= ONE) && (r_fac2[2] <= ONE)))
        else $error("ramp factor above one");

    // a full pipeline with a stalled output takes no new transaction
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline full and stalled");

    // a stalled stage keeps its transaction
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !w_rdy5) |=> r_v4)
        else $error("stage four dropped a transaction");
`endif

endmodule

`default_nettype wire

### verif/hls_to_rgb_converter_unit_tb.sv
// hls_to_rgb_converter_unit_tb: self-checking bench for the hls to rgb converter
// checks every rgb result against a fixed point predictor in this file
// depends on hls2rgb_pkg and hls_to_rgb_converter_unit
`timescale 1ns / 1ps

module hls_to_rgb_converter_unit_tb;

    localparam int HUE_W       = hls2rgb_pkg::HUE_W;
    localparam int CH_W        = hls2rgb_pkg::CH_W;
    localparam int IN_TDATA_W  = hls2rgb_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = hls2rgb_pkg::OUT_TDATA_W;

    localparam int FRAC_BITS = 16;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam int CH_MAX    = (1 << CH_W) - 1;

    // bit offsets of the fields in the slave and master tdata
    localparam int L_LSB = HUE_W;
    localparam int S_LSB = HUE_W + CH_W;
    localparam int G_LSB = CH_W;
    localparam int B_LSB = 2 * CH_W;

    localparam int N_RANDOM       = 1950;
    localparam int HOLD_AFTER_OUT = 400;   // results seen before the long output stall
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;    // pipeline is five deep, this is plenty
    localparam int IDLE_LIMIT     = 5000;  // longest quiet stretch is the long stall

    localparam logic [63:0] ONE_FX   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MASK_FX  = ONE_FX - 64'd1;
    localparam logic [63:0] THIRD_FX = ONE_FX / 64'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // clock, reset and bus signals, all known from time zero
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic                   m_tready   = 1'b0;
    wire                    o_s_tready;
    wire                    o_m_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_tdata;

    logic [IN_TDATA_W-1:0]  pending_hls[$];   // items waiting to be offered
    t_rgb                   expected_rgb[$];  // predictions of results still to come

    int n_in        = 0;
    int n_out       = 0;
    int n_errors    = 0;
    int n_in_stalls = 0;
    int idle_cycles = 0;

    // sender burst shaping, owned by the driver
    int burst_left = 1;
    int gap_left   = 0;

    // receiver pattern, owned by the receiver process
    int  rx_mode      = 0;
    int  rx_mode_left = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    int  rx_tick      = 0;

    hls_to_rgb_converter_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // piecewise hue ramp for one channel hue in [0, ONE)
    function automatic logic [63:0] ramp_level(input logic [63:0] m1, input logic [63:0] m2,
                                               input logic [63:0] h);
        logic [63:0] diff;
        logic [63:0] h6;
        diff = m2 - m1;
        h6   = 64'd6 * h;
        if (h6 < ONE_FX)
            return m1 + ((diff * h6) >> FRAC_BITS);
        if (64'd2 * h < ONE_FX)
            return m2;
        // the 2/3 corner folds into 4*ONE - 6h exactly
        if (64'd3 * h < 64'd2 * ONE_FX)
            return m1 + ((diff * (64'd4 * ONE_FX - h6)) >> FRAC_BITS);
        return m1;
    endfunction

    // expected colour for one hls triple
    function automatic t_rgb predict_rgb(input logic [HUE_W-1:0] hue_in,
                                         input logic [CH_W-1:0] light_in,
                                         input logic [CH_W-1:0] sat_in);
        logic [63:0] h;
        logic [63:0] l;
        logic [63:0] s;
        logic [63:0] m1;
        logic [63:0] m2;
        t_rgb        res;
        h = 64'(hue_in) & MASK_FX;
        // lightness and saturation above one are clipped
        l = (64'(light_in) > ONE_FX) ? ONE_FX : 64'(light_in);
        s = (64'(sat_in) > ONE_FX) ? ONE_FX : 64'(sat_in);
        if (s == 64'd0) begin
            // grey: every channel is the lightness
            res.red   = l[CH_W-1:0];
            res.green = l[CH_W-1:0];
            res.blue  = l[CH_W-1:0];
        end else begin
            if (l <= ONE_FX / 64'd2)
                m2 = (l * (ONE_FX + s)) >> FRAC_BITS;
            else
                m2 = l + s - ((l * s) >> FRAC_BITS);
            m1 = 64'd2 * l - m2;
            res.red   = CH_W'(ramp_level(m1, m2, (h + THIRD_FX) & MASK_FX));
            res.green = CH_W'(ramp_level(m1, m2, h));
            res.blue  = CH_W'(ramp_level(m1, m2, (h + ONE_FX - THIRD_FX) & MASK_FX));
        end
        return res;
    endfunction

    // pack one triple into slave tdata, zeros above saturation
    task automatic queue_hls(input int hue_v, input int light_v, input int sat_v);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[L_LSB-1:0]     = HUE_W'(hue_v);
        word[S_LSB-1:L_LSB] = CH_W'(light_v);
        word[S_LSB+CH_W-1:S_LSB] = CH_W'(sat_v);
        pending_hls.push_back(word);
    endtask

    // random triple, weighted towards the ramp corners and the clipping range
    task automatic queue_random_hls();
        int hue_v;
        int light_v;
        int sat_v;
        int corner;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: corner = 0;
                1: corner = ONE_I / 6 + 1;
                2: corner = ONE_I / 2;
                3: corner = (2 * ONE_I) / 3 + 1;
                4: corner = ONE_I / 3;
                default: corner = ONE_I - ONE_I / 3;
            endcase
            hue_v = (corner + $urandom_range(0, 4) - 2 + ONE_I) % ONE_I;
        end else begin
            hue_v = $urandom_range(0, ONE_I - 1);
        end
        case ($urandom_range(0, 7))
            0:       light_v = 0;
            1:       light_v = ONE_I;
            2:       light_v = $urandom_range(ONE_I + 1, CH_MAX);
            3:       light_v = $urandom_range(ONE_I / 2 - 2, ONE_I / 2 + 2);
            default: light_v = $urandom_range(0, ONE_I);
        endcase
        case ($urandom_range(0, 7))
            0:       sat_v = 0;
            1:       sat_v = ONE_I;
            2:       sat_v = $urandom_range(ONE_I + 1, CH_MAX);
            default: sat_v = $urandom_range(1, ONE_I);
        endcase
        queue_hls(hue_v, light_v, sat_v);
    endtask

    // driver: offers pending items in bursts with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                // transaction taken at this edge, predict its result now
                expected_rgb.push_back(predict_rgb(s_tdata[L_LSB-1:0], s_tdata[S_LSB-1:L_LSB],
                                                   s_tdata[S_LSB+CH_W-1:S_LSB]));
                n_in <= n_in + 1;
            end
            if (s_tvalid && !o_s_tready) begin
                // hold the item until the block takes it
                n_in_stalls <= n_in_stalls + 1;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_hls.size() > 0) begin
                s_tdata  <= pending_hls.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    // about a quarter of bursts run straight into the next
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changes stall pattern now and then, and once holds off long enough
    // for the pipeline to fill and push back on the slave side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && n_out >= HOLD_AFTER_OUT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 128);
            end else begin
                rx_mode_left = rx_mode_left - 1;
            end
            rx_tick = rx_tick + 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= rx_tick[1];
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: each result against the oldest prediction, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            n_out <= n_out + 1;
            if (expected_rgb.size() == 0) begin
                $error("rgb transaction with no prediction waiting: tdata %h", o_m_tdata);
                n_errors = n_errors + 1;
            end else begin
                t_rgb want;
                want = expected_rgb.pop_front();
                if (o_m_tdata[G_LSB-1:0] !== want.red) begin
                    $error("red mismatch: expected %0d, actual %0d", want.red,
                           o_m_tdata[G_LSB-1:0]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[B_LSB-1:G_LSB] !== want.green) begin
                    $error("green mismatch: expected %0d, actual %0d", want.green,
                           o_m_tdata[B_LSB-1:G_LSB]);
                    n_errors = n_errors + 1;
                end
                if (o_m_tdata[B_LSB+CH_W-1:B_LSB] !== want.blue) begin
                    $error("blue mismatch: expected %0d, actual %0d", want.blue,
                           o_m_tdata[B_LSB+CH_W-1:B_LSB]);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // watchdog: ends a run that has gone quiet on both sides for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // directed items: field extremes, ramp corners, clipping and grey
        queue_hls(0, 0, 0);
        queue_hls(ONE_I - 1, CH_MAX, CH_MAX);          // all ones, both clipped
        queue_hls(12345, 40000, 0);                     // grey
        queue_hls(ONE_I / 3, ONE_I, ONE_I);             // white
        queue_hls(0, ONE_I / 2, ONE_I);                 // pure red
        queue_hls(ONE_I / 3, ONE_I / 2, ONE_I);         // pure green
        queue_hls(ONE_I - ONE_I / 3, ONE_I / 2, ONE_I); // pure blue
        queue_hls(ONE_I / 6, ONE_I / 2, ONE_I);         // last point of the rise
        queue_hls(ONE_I / 6 + 1, ONE_I / 2, ONE_I);     // first point held high
        queue_hls(ONE_I / 2 - 1, 30000, 50000);
        queue_hls(ONE_I / 2, 30000, 50000);             // start of the fall
        queue_hls((2 * ONE_I) / 3, 50000, 30000);
        queue_hls((2 * ONE_I) / 3 + 1, 50000, 30000);   // start of the low run
        queue_hls(20000, ONE_I / 2, 1);                 // lightness at the m2 split
        queue_hls(20000, ONE_I / 2 + 1, 1);
        queue_hls(20000, ONE_I / 2 + 1, ONE_I);
        queue_hls(50000, ONE_I + 1, 30000);             // lightness just over one
        queue_hls(50000, 30000, ONE_I + 1);             // saturation just over one
        queue_hls(7000, 1, ONE_I);
        queue_hls(7000, ONE_I - 1, CH_MAX);
        queue_hls(ONE_I - 1, 0, ONE_I);                 // black with full saturation
        queue_hls(43690, 65000, CH_MAX - 1);
        for (int i = 0; i < N_RANDOM; i++)
            queue_random_hls();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything offered, taken and answered
        do begin
            @(negedge i_clk);
        end while (pending_hls.size() != 0 || s_tvalid || expected_rgb.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d hls transactions in, %0d rgb transactions out, clipping and grey cases",
                 n_in, n_out);
        $display("slave side held off for %0d cycles while results were backed up",
                 n_in_stalls);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
